// File: hw/rtl/smc_pkg.sv
`default_nettype none

package smc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam logic [TIME_W-1:0] RUN_TIMEOUT_RST = 32'd30000;
    localparam logic INTERF_EN_RST = 1'b1;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

    typedef enum logic [3:0] {
        SH_CLOSED    = 4'd0,
        SH_OPEN      = 4'd1,
        SH_ABORTED   = 4'd2,
        SH_ERROR     = 4'd3,
        SH_OPENING   = 4'd4,
        SH_CLOSING   = 4'd5,
        SH_OPEN_BLK  = 4'd6,
        SH_CLOSE_BLK = 4'd7,
        SH_UNKNOWN   = 4'd8
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2,
        OP_ABORT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MC_NONE  = 2'd0,
        MC_OPEN  = 2'd1,
        MC_CLOSE = 2'd2,
        MC_STOP  = 2'd3
    } motor_t;

    typedef enum logic {
        REG_RUN_TIMEOUT = 1'b0,
        REG_INTERF_EN   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0] run_timeout_ms;
        logic              interference_enabled;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              interference_switch;
        logic              open_switch;
        logic              closed_switch;
        op_t               op;
    } tick_t;

    typedef struct packed {
        motor_t     motor_cmd;
        logic       blocked_closing;
        logic [2:0] shutter_state;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/smc_cfg_regs.sv
`default_nettype none

module smc_cfg_regs
    import smc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_index,
    input  wire logic [TIME_W-1:0] cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_RUN_TIMEOUT: cfg_next.run_timeout_ms = cfg_data;
                REG_INTERF_EN:   cfg_next.interference_enabled = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_timeout_ms       <= RUN_TIMEOUT_RST;
            cfg_reg.interference_enabled <= INTERF_EN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hw/rtl/smc_step.sv
`default_nettype none

module smc_step
    import smc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  advance,
    input  wire tick_t tick,
    output result_t    result
);

    state_t            state_reg;
    state_t            state_next;
    state_t            st_cur;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] elapsed;
    logic              timed_out;
    logic              inter;
    logic              load_start;
    motor_t            motor;

    assign inter     = cfg.interference_enabled & tick.interference_switch;
    assign elapsed   = tick.now_ms - start_reg;
    assign timed_out = elapsed > cfg.run_timeout_ms;

    // first request after reset resolves position from the limit switches
    always_comb
    begin
        if (state_reg == SH_UNKNOWN)
            st_cur = tick.closed_switch ? SH_CLOSED :
                     (tick.open_switch ? SH_OPEN : SH_ABORTED);
        else
            st_cur = state_reg;
    end

    always_comb
    begin
        state_next = st_cur;
        unique case (st_cur) inside
            SH_CLOSED:
                if (tick.op == OP_OPEN)
                    state_next = inter ? SH_OPEN_BLK : SH_OPENING;
            SH_OPEN:
                if (tick.op == OP_CLOSE)
                    state_next = inter ? SH_CLOSE_BLK : SH_CLOSING;
            SH_ABORTED, SH_ERROR:
                if (tick.op == OP_OPEN)
                    state_next = SH_OPENING;
                else if (tick.op == OP_CLOSE)
                    state_next = SH_CLOSING;
            SH_OPEN_BLK:
                if (!inter)
                    state_next = SH_OPENING;
            SH_CLOSE_BLK:
                if (!inter)
                    state_next = SH_CLOSING;
            SH_OPENING:
                if (tick.open_switch)
                    state_next = SH_OPEN;
                else if (inter)
                    state_next = SH_OPEN_BLK;
                else if (tick.op == OP_ABORT || tick.op == OP_OPEN)
                    state_next = SH_ABORTED;
                else if (tick.op == OP_CLOSE)
                    state_next = SH_CLOSING;
                else if (timed_out)
                    state_next = SH_ERROR;
            SH_CLOSING:
                if (tick.closed_switch)
                    state_next = SH_CLOSED;
                else if (inter)
                    state_next = SH_CLOSE_BLK;
                else if (tick.op == OP_ABORT || tick.op == OP_CLOSE)
                    state_next = SH_ABORTED;
                else if (tick.op == OP_OPEN)
                    state_next = SH_OPENING;
                else if (timed_out)
                    state_next = SH_ERROR;
            default:
                state_next = SH_ERROR;
        endcase
    end

    always_comb
    begin
        motor      = MC_NONE;
        load_start = 1'b0;
        unique case (st_cur) inside
            SH_CLOSED:
                if (tick.op == OP_OPEN && !inter)
                begin
                    motor      = MC_OPEN;
                    load_start = 1'b1;
                end
            SH_OPEN:
                if (tick.op == OP_CLOSE && !inter)
                begin
                    motor      = MC_CLOSE;
                    load_start = 1'b1;
                end
            SH_ABORTED, SH_ERROR:
                if (tick.op == OP_OPEN)
                begin
                    motor      = MC_OPEN;
                    load_start = 1'b1;
                end
                else if (tick.op == OP_CLOSE)
                begin
                    motor      = MC_CLOSE;
                    load_start = 1'b1;
                end
            SH_OPEN_BLK:
                if (!inter)
                begin
                    motor      = MC_OPEN;
                    load_start = 1'b1;
                end
            SH_CLOSE_BLK:
                if (!inter)
                begin
                    motor      = MC_CLOSE;
                    load_start = 1'b1;
                end
            SH_OPENING:
                if (tick.open_switch || inter || tick.op == OP_ABORT || tick.op == OP_OPEN)
                    motor = MC_STOP;
                else if (tick.op == OP_CLOSE)
                    motor = MC_CLOSE;
                else if (timed_out)
                    motor = MC_STOP;
            SH_CLOSING:
                if (tick.closed_switch || inter || tick.op == OP_ABORT
                    || tick.op == OP_CLOSE)
                    motor = MC_STOP;
                else if (tick.op == OP_OPEN)
                    motor = MC_OPEN;
                else if (timed_out)
                    motor = MC_STOP;
            default:
                motor = MC_STOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SH_UNKNOWN;
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_start)
            start_reg <= tick.now_ms;
    end

    always_comb
    begin
        result.motor_cmd = motor;
        if (state_next == SH_CLOSE_BLK)
        begin
            result.blocked_closing = 1'b1;
            result.shutter_state   = 3'd0;
        end
        else
        begin
            result.blocked_closing = 1'b0;
            result.shutter_state   = state_next[2:0];
        end
    end

`ifndef SYNTHESIS
    a_resolved: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> state_reg != SH_UNKNOWN)
        else $error("state unresolved after a request");

    a_stays_resolved: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != SH_UNKNOWN |=> state_reg != SH_UNKNOWN)
        else $error("state returned to unresolved");

    a_run_timer: assert property (@(posedge clk) disable iff (!rst_n)
        advance && load_start |=> state_reg == SH_OPENING || state_reg == SH_CLOSING)
        else $error("run timer started without motion");

    a_stop_motor: assert property (@(posedge clk) disable iff (!rst_n)
        advance && motor == MC_STOP |=> state_reg != SH_OPENING && state_reg != SH_CLOSING)
        else $error("motor stopped while still in motion");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/shutter_motion_controller.sv
`default_nettype none
// Shutter motion controller.
// A request is held in the input register, and its result in the result register.
// Throughput: one request per cycle while the result side accepts; the state update is one pass between the
// input register and the result register.
// Reset: state unresolved until the first request, run timeout 30000 ms,
// interference enabled, input and result registers empty.

module shutter_motion_controller
    import smc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [1:0] op, [2] closed_switch, [3] open_switch, [4] interference_switch,
    // [36:5] now_ms, [39:37] zero
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [2:0] shutter_state, [3] blocked_closing, [5:4] motor_cmd, [7:6] zero
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic                   cfg_index,
    input  wire logic [TIME_W-1:0]      cfg_data
);

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;
    logic    advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready  = ~in_valid_reg | advance;

    smc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    smc_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .tick    (tick_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            tick_reg <= tick_t'(s_tdata[$bits(tick_t)-1:0]);
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_reg};

endmodule

`default_nettype wire

// File: tb/smc_checker.sv
`default_nettype none

module smc_checker
    import smc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic                   cfg_index,
    input  wire logic [TIME_W-1:0]      cfg_data,
    output int                          errors,
    output int                          pending
);

    state_t            shutter_st;
    logic [TIME_W-1:0] run_start_ms;
    cfg_t              cfg;
    result_t           expected_results[$];
    int                fail_cnt;

    assign errors  = fail_cnt;
    assign pending = expected_results.size();

    function automatic result_t step_shutter(tick_t t);
        state_t            st;
        motor_t            mc;
        logic              intf;
        logic [TIME_W-1:0] elapsed;
        logic [3:0]        code;
        result_t           r;
        intf = cfg.interference_enabled & t.interference_switch;
        st = shutter_st;
        mc = MC_NONE;
        if (st == SH_UNKNOWN)
            st = t.closed_switch ? SH_CLOSED : (t.open_switch ? SH_OPEN : SH_ABORTED);
        elapsed = t.now_ms - run_start_ms;
        case (st) inside
            SH_CLOSED:
                if (t.op == OP_OPEN)
                begin
                    if (intf)
                        st = SH_OPEN_BLK;
                    else
                    begin
                        run_start_ms = t.now_ms;
                        st = SH_OPENING;
                        mc = MC_OPEN;
                    end
                end
            SH_OPEN:
                if (t.op == OP_CLOSE)
                begin
                    if (intf)
                        st = SH_CLOSE_BLK;
                    else
                    begin
                        run_start_ms = t.now_ms;
                        st = SH_CLOSING;
                        mc = MC_CLOSE;
                    end
                end
            SH_ABORTED, SH_ERROR:
                if (t.op == OP_OPEN)
                begin
                    run_start_ms = t.now_ms;
                    st = SH_OPENING;
                    mc = MC_OPEN;
                end
                else if (t.op == OP_CLOSE)
                begin
                    run_start_ms = t.now_ms;
                    st = SH_CLOSING;
                    mc = MC_CLOSE;
                end
            SH_OPEN_BLK:
                if (!intf)
                begin
                    run_start_ms = t.now_ms;
                    st = SH_OPENING;
                    mc = MC_OPEN;
                end
            SH_CLOSE_BLK:
                if (!intf)
                begin
                    run_start_ms = t.now_ms;
                    st = SH_CLOSING;
                    mc = MC_CLOSE;
                end
            SH_OPENING:
                if (t.open_switch)
                begin
                    st = SH_OPEN;
                    mc = MC_STOP;
                end
                else if (intf)
                begin
                    st = SH_OPEN_BLK;
                    mc = MC_STOP;
                end
                else if (t.op == OP_ABORT || t.op == OP_OPEN)
                begin
                    st = SH_ABORTED;
                    mc = MC_STOP;
                end
                else if (t.op == OP_CLOSE)
                begin
                    st = SH_CLOSING;
                    mc = MC_CLOSE;
                end
                else if (elapsed > cfg.run_timeout_ms)
                begin
                    st = SH_ERROR;
                    mc = MC_STOP;
                end
            SH_CLOSING:
                if (t.closed_switch)
                begin
                    st = SH_CLOSED;
                    mc = MC_STOP;
                end
                else if (intf)
                begin
                    st = SH_CLOSE_BLK;
                    mc = MC_STOP;
                end
                else if (t.op == OP_ABORT || t.op == OP_CLOSE)
                begin
                    st = SH_ABORTED;
                    mc = MC_STOP;
                end
                else if (t.op == OP_OPEN)
                begin
                    st = SH_OPENING;
                    mc = MC_OPEN;
                end
                else if (elapsed > cfg.run_timeout_ms)
                begin
                    st = SH_ERROR;
                    mc = MC_STOP;
                end
            default:
            begin
                st = SH_ERROR;
                mc = MC_STOP;
            end
        endcase
        shutter_st = st;
        code = st;
        r.motor_cmd = mc;
        r.blocked_closing = (st == SH_CLOSE_BLK);
        r.shutter_state = (st == SH_CLOSE_BLK) ? 3'd0 : code[2:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        result_t got_r;
        if (!rst_n)
        begin
            shutter_st = SH_UNKNOWN;
            run_start_ms = '0;
            cfg.run_timeout_ms = RUN_TIMEOUT_RST;
            cfg.interference_enabled = INTERF_EN_RST;
            expected_results.delete();
            fail_cnt = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_RUN_TIMEOUT)
                    cfg.run_timeout_ms = cfg_data;
                else
                    cfg.interference_enabled = cfg_data[0];
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(step_shutter(tick_t'(s_tdata[36:0])));
            if (m_tvalid && m_tready)
            begin
                got_r = result_t'(m_tdata[5:0]);
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result, tdata %h", m_tdata);
                    fail_cnt++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got_r.shutter_state != exp_r.shutter_state)
                    begin
                        $error("shutter_state: expected %0d, got %0d",
                               exp_r.shutter_state, got_r.shutter_state);
                        fail_cnt++;
                    end
                    if (got_r.blocked_closing != exp_r.blocked_closing)
                    begin
                        $error("blocked_closing: expected %0d, got %0d",
                               exp_r.blocked_closing, got_r.blocked_closing);
                        fail_cnt++;
                    end
                    if (got_r.motor_cmd != exp_r.motor_cmd)
                    begin
                        $error("motor_cmd: expected %0d, got %0d",
                               exp_r.motor_cmd, got_r.motor_cmd);
                        fail_cnt++;
                    end
                    if (m_tdata[7:6] != 2'b00)
                    begin
                        $error("pad: expected 0, got %0d", m_tdata[7:6]);
                        fail_cnt++;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb
    import smc_pkg::*;
();

    localparam int NUM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int HOLD_CYCLES = 300;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_index;
    logic [TIME_W-1:0]      cfg_data;
    int                     errors;
    int                     pending;

    int                tx_idle_pct;
    int                rx_stall_pct;
    int                hold_req;
    int                hold_served;
    logic [TIME_W-1:0] now_cur;

    shutter_motion_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    smc_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #3_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // result side: random stalls, plus long hold-offs on request
    initial
    begin
        m_tready = 1'b0;
        hold_served = 0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_req)
            begin
                hold_served++;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                m_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_tick(input op_t op, input logic c_sw, input logic o_sw,
                             input logic i_sw, input logic [TIME_W-1:0] now);
        tick_t t;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        t.op = op;
        t.closed_switch = c_sw;
        t.open_switch = o_sw;
        t.interference_switch = i_sw;
        t.now_ms = now;
        s_tdata = {3'b000, t};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_tick();
        int   r;
        op_t  op;
        r = $urandom_range(99);
        op = (r < 50) ? OP_NONE : (r < 70) ? OP_OPEN : (r < 90) ? OP_CLOSE : OP_ABORT;
        r = $urandom_range(99);
        if (r < 5)
            now_cur = $urandom;
        else if (r < 75)
            now_cur = now_cur + $urandom_range(0, 2000);
        else if (r < 95)
            now_cur = now_cur + $urandom_range(0, 60000);
        send_tick(op, $urandom_range(99) < 20, $urandom_range(99) < 20,
                  $urandom_range(99) < 15, now_cur);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [TIME_W-1:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        logic [TIME_W-1:0] timeouts [NUM_PHASES];
        logic              interf [NUM_PHASES];
        int                tx_modes [4];
        int                rx_modes [4];
        timeouts = '{32'd30000, 32'd0, 32'hFFFF_FFFF, 32'd500, 32'd30000, 32'd5000};
        interf = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        tx_modes = '{0, 51, 0, 12};
        rx_modes = '{0, 0, 51, 12};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_RUN_TIMEOUT;
        cfg_data = '0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req = 0;
        now_cur = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset timeout 30000, interference enabled
        send_tick(OP_NONE,  1, 0, 0, 32'd0);          // resolves to closed
        send_tick(OP_ABORT, 1, 0, 0, 32'd5);
        send_tick(OP_OPEN,  1, 0, 1, 32'd10);         // opening blocked
        send_tick(OP_NONE,  1, 0, 0, 32'd100);        // opening
        send_tick(OP_NONE,  0, 0, 0, 32'd30100);      // elapsed == timeout
        send_tick(OP_NONE,  0, 0, 0, 32'd30101);      // error
        send_tick(OP_CLOSE, 0, 0, 0, 32'd30200);      // closing
        send_tick(OP_NONE,  1, 0, 0, 32'd30300);      // closed
        send_tick(OP_OPEN,  1, 0, 0, 32'hFFFF_FF00);
        send_tick(OP_NONE,  0, 0, 0, 32'h0000_7400);  // wrapped, not yet timed out
        send_tick(OP_NONE,  0, 1, 0, 32'h0000_7401);  // open
        send_tick(OP_CLOSE, 0, 1, 1, 32'h0000_7500);  // closing blocked
        send_tick(OP_NONE,  0, 1, 0, 32'h0000_7600);  // closing
        send_tick(OP_OPEN,  0, 0, 0, 32'h0000_7700);  // reverse to opening
        send_tick(OP_CLOSE, 0, 0, 0, 32'h0000_7800);  // reverse to closing
        send_tick(OP_ABORT, 0, 0, 0, 32'h0000_7900);  // aborted
        send_tick(OP_OPEN,  0, 0, 0, 32'h0000_7A00);
        send_tick(OP_NONE,  0, 0, 1, 32'h0000_7B00);  // opening blocked, stop
        send_tick(OP_NONE,  0, 0, 0, 32'h0000_7C00);
        send_tick(OP_OPEN,  0, 0, 0, 32'h0000_7D00);  // open again aborts
        send_tick(OP_CLOSE, 0, 0, 0, 32'hFFFF_0000);
        send_tick(OP_NONE,  0, 0, 1, 32'hFFFF_0010);  // closing blocked, stop
        send_tick(OP_NONE,  0, 0, 0, 32'hFFFF_0020);
        send_tick(OP_NONE,  0, 0, 0, 32'hFFFF_FFFF);  // closing times out
        send_tick(OP_CLOSE, 0, 0, 0, 32'hFFFF_FFFF);
        send_tick(OP_CLOSE, 0, 0, 0, 32'h0000_0000);  // close again aborts
        now_cur = 32'hFFFF_F000;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            if (p > 0)
            begin
                write_reg(REG_RUN_TIMEOUT, timeouts[p]);
                write_reg(REG_INTERF_EN, {31'd0, interf[p]});
            end
            tx_idle_pct = tx_modes[p % 4];
            rx_stall_pct = rx_modes[p % 4];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ((p == 1 || p == 4) && n == 60)
                    hold_req++;
                if (p == 3 && n == 80)
                    drain();
                send_random_tick();
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
